// ===== hdl/l2sw_pkg.sv =====
// Package for the learning VLAN switch: field widths, register indexes, mode codes.
// No dependencies.
package l2sw_pkg;

  localparam int unsigned MacW  = 48;
  localparam int unsigned VlanW = 12;
  localparam int unsigned PortW = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegPortModes   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAccessVlans = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTrunk0      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTrunk3      = 3'd5;

  localparam logic [1:0] ModeAccess = 2'd1;
  localparam logic [1:0] ModeTrunk  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic scan;       // compare current table entry
    logic learn;      // write source entry
    logic finish;     // form result into output register
  } l2sw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // current entry is last of the table
  } l2sw_sts_t;

endpackage

// ===== hdl/l2sw_ctrl.sv =====
// Controller state machine for the learning VLAN switch.
// Depends on l2sw_pkg.
module l2sw_ctrl
  import l2sw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_busy_i,
  input  l2sw_sts_t sts_i,
  output l2sw_cmd_t cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StLearn = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = StLearn;
      end
      StLearn: begin
        cmd_o.learn = 1'b1;
        state_d     = StDone;
      end
      StDone: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle) else $error("load outside idle");
  a_learn_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.learn |=> state_q == StDone) else $error("learn not followed by done");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !out_busy_i) else $error("finish with full output");

endmodule

// ===== hdl/l2sw_dp.sv =====
// Datapath: config registers, MAC table scan, VLAN filter, output register.
// Depends on l2sw_pkg.
module l2sw_dp
  import l2sw_pkg::*;
#(
  parameter int unsigned NumPorts   = 4,
  parameter int unsigned TableDepth = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  l2sw_cmd_t         cmd_i,
  output l2sw_sts_t         sts_o,
  input  logic [111:0]      in_data_i,
  input  logic              cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [47:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       out_data_o
);

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic [7:0]  modes_q;
  logic [47:0] access_q;
  logic [47:0] trunk_q [4];

  logic [TableDepth-1:0] valid_q;
  logic [MacW-1:0]  addr_mem [TableDepth];
  logic [PortW-1:0] port_mem [TableDepth];

  logic [PortW-1:0] ing_q;
  logic [MacW-1:0]  src_q, dst_q;
  logic [VlanW-1:0] vlan_q;
  logic             absent_q;

  logic [IdxW-1:0]  scan_q;
  logic             src_hit_q, dst_hit_q, free_found_q;
  logic [IdxW-1:0]  src_idx_q, free_idx_q;
  logic [PortW-1:0] dst_port_q;

  logic             out_valid_q;
  logic [15:0]      out_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modes_q  <= '0;
      access_q <= '0;
      for (int k = 0; k < 4; k++) trunk_q[k] <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegPortModes) modes_q <= cfg_data_i[7:0];
      else if (cfg_index_i == RegAccessVlans) access_q <= cfg_data_i;
      else if (cfg_index_i >= RegTrunk0 && cfg_index_i <= RegTrunk3)
        trunk_q[2'(cfg_index_i - RegTrunk0)] <= cfg_data_i;
    end
  end

  // scan one entry a cycle
  logic [MacW-1:0]  e_addr;
  logic [PortW-1:0] e_port;
  logic             e_valid;
  assign e_addr  = addr_mem[scan_q];
  assign e_port  = port_mem[scan_q];
  assign e_valid = valid_q[scan_q];
  assign sts_o.scan_last = (scan_q == IdxW'(TableDepth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      scan_q  <= '0;
    end else begin
      if (cmd_i.load) scan_q <= '0;
      else if (cmd_i.scan && !sts_o.scan_last) scan_q <= scan_q + 1'b1;
      if (cmd_i.learn && !absent_q && (src_hit_q || free_found_q))
        valid_q[src_hit_q ? src_idx_q : free_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ing_q        <= in_data_i[1:0];
      src_q        <= in_data_i[49:2];
      dst_q        <= in_data_i[97:50];
      vlan_q       <= in_data_i[98] ? in_data_i[110:99] : '0;
      absent_q     <= ({30'd0, in_data_i[1:0]} >= 32'(NumPorts));
      src_hit_q    <= 1'b0;
      dst_hit_q    <= 1'b0;
      free_found_q <= 1'b0;
    end
    if (cmd_i.scan) begin
      if (e_valid && e_addr == src_q && !src_hit_q) begin
        src_hit_q <= 1'b1;
        src_idx_q <= scan_q;
      end
      if (!e_valid && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= scan_q;
      end
      if (e_valid && e_addr == dst_q && !dst_hit_q) begin
        dst_hit_q  <= 1'b1;
        dst_port_q <= e_port;
      end
    end
    if (cmd_i.learn && !absent_q && (src_hit_q || free_found_q)) begin
      addr_mem[src_hit_q ? src_idx_q : free_idx_q] <= src_q;
      port_mem[src_hit_q ? src_idx_q : free_idx_q] <= ing_q;
      // table was scanned before the write: a destination equal to this
      // source now resolves to the ingress port
      if (dst_q == src_q) begin
        dst_hit_q  <= 1'b1;
        dst_port_q <= ing_q;
      end
    end
  end

  // result
  logic       flood;
  logic [3:0] cand, egr, untag;
  logic [1:0] mode;
  always_comb begin
    flood = (dst_q == {MacW{1'b1}}) || !dst_hit_q;
    cand  = '0;
    egr   = '0;
    untag = '0;
    mode  = '0;
    for (int p = 0; p < NumPorts; p++) begin
      cand[p] = flood ? (PortW'(p) != ing_q) : (dst_port_q == PortW'(p));
      mode = modes_q[2*p +: 2];
      if (cand[p]) begin
        if (mode == ModeAccess && access_q[12*p +: 12] == vlan_q) begin
          egr[p] = 1'b1; untag[p] = 1'b1;
        end else if (mode == ModeTrunk) begin
          for (int k = 0; k < 4; k++)
            if (trunk_q[p][12*k +: 12] != '0 && trunk_q[p][12*k +: 12] == vlan_q)
              egr[p] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.finish) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  logic learn_drop;
  assign learn_drop = !src_hit_q && !free_found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (absent_q) out_q <= '0;
      else out_q <= {6'd0, learn_drop, flood, untag, egr};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_untag_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q[7:4] & ~out_q[3:0]) == 4'd0) else $error("untag outside egress");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q)) else $error("result lost");
  a_scan_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> scan_q == '0) else $error("scan not restarted");

endmodule

// ===== hdl/l2_mac_learning_vlan_switch_top.sv =====
// Top level of the learning VLAN switch: controller plus datapath.
// Depends on l2sw_pkg, l2sw_ctrl, l2sw_dp.
//
// Use: one frame header is a beat on s_axis (tdata = ingress_port, src,
// dst, is_tagged, tag_vlan from bit 0 up). One result beat leaves on m_axis
// (egress mask, untag mask, flooded, learn_dropped from bit 0 up).
// Configuration is written on cfg_* (index 0 port modes, 1 access VLANs,
// 2..5 trunk member lists) while no header is in flight.
// After acceptance, one entry of the address table is compared per cycle
// against both source and destination, then comes a learn write, then the
// VLAN filter into the output register. A new header is accepted only
// after the result of the previous one is registered and the controller
// is back in idle.
// The output register frees the controller once the result sits there; a
// stalled receiver holds the result and the next header waits in the final
// step until the register empties.
// Reset clears the table valid bits, configuration and the output valid flag.
module l2_mac_learning_vlan_switch_top
  import l2sw_pkg::*;
#(
  parameter int unsigned NUM_PORTS   = 4,
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ingress_port[1:0], src_address[49:2], dst_address[97:50],
  // is_tagged[98], tag_vlan[110:99], zero fill
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // egress_mask[3:0], untag_mask[7:4], flooded[8], learn_dropped[9], zero fill
  output logic [15:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [47:0]  cfg_data_i
);

  l2sw_cmd_t cmd;
  l2sw_sts_t sts;

  assign cfg_ready_o = 1'b1;

  l2sw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (m_axis_tvalid && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  l2sw_dp #(
    .NumPorts   (NUM_PORTS),
    .TableDepth (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
